### rtl/kott_pkg.sv
`default_nettype none

package kott_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W  = 10;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_TICK_RATE = 1'b0;
  localparam logic CFG_MIN_DELAY = 1'b1;

  localparam logic [CFG_W-1:0] TICK_RATE_RST = CFG_W'(100);
  localparam logic [CFG_W-1:0] MIN_DELAY_RST = CFG_W'(10);

  // Millisecond to tick conversion: product of a 32-bit delay and a 10-bit rate,
  // divided by 1000 as a shift by three followed by a division by 125. The
  // division by 125 is a multiplication by a rounded-up reciprocal that is exact
  // for every dividend below 2**DIVD_W.
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned PROD_W     = WORD_W + CFG_W;
  localparam int unsigned MS_SHIFT   = 3;
  localparam int unsigned MS_ODD     = MS_PER_SEC >> MS_SHIFT;
  localparam int unsigned ODD_BITS   = $clog2(MS_ODD);
  localparam int unsigned DIVD_W     = PROD_W - MS_SHIFT;
  localparam int unsigned RECIP_SH   = DIVD_W + ODD_BITS;
  localparam int unsigned RECIP_W    = DIVD_W + 1;
  localparam int unsigned HALF_W     = RECIP_W / 2;
  localparam int unsigned ACC_W      = DIVD_W + RECIP_W;
  localparam int unsigned QUOT_W     = ACC_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP_ODD =
      RECIP_W'(((64'd1 << RECIP_SH) + 64'(MS_ODD) - 64'd1) / 64'(MS_ODD));

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] param;
    logic [WORD_W-1:0] ctx;
    logic [WORD_W-1:0] ticks;
  } entry_t;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] param;
    logic [WORD_W-1:0] ctx;
  } result_t;

endpackage

`default_nettype wire

### rtl/kott_entry_ram.sv
`default_nettype none

module kott_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire kott_pkg::entry_t  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output kott_pkg::entry_t       rd_data_o
);
  import kott_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds while no read is issued, so a stalled consumer keeps its entry.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

### rtl/kott_tick_conv.sv
`default_nettype none

module kott_tick_conv (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] delay_i,
  input  wire logic [9:0]  rate_i,
  output logic      [31:0] ticks_o,
  output logic             done_o
);
  import kott_pkg::*;

  localparam logic [1:0] CV_IDLE = 2'd0;
  localparam logic [1:0] CV_MUL  = 2'd1;
  localparam logic [1:0] CV_LO   = 2'd2;
  localparam logic [1:0] CV_HI   = 2'd3;

  logic [1:0]               cst_q, cst_d;
  logic [WORD_W-1:0]        a_q;
  logic [CFG_W-1:0]         b_q;
  logic [PROD_W-1:0]        prod;
  logic [DIVD_W-1:0]        divd_q;
  logic [HALF_W-1:0]        recip_half;
  logic [DIVD_W+HALF_W-1:0] part;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [QUOT_W-1:0]        quot;

  assign prod = {{CFG_W{1'b0}}, a_q} * {{WORD_W{1'b0}}, b_q};

  // The reciprocal is applied in two halves, low then high, on one multiplier.
  assign recip_half = (cst_q == CV_HI) ? RECIP_ODD[RECIP_W-1:HALF_W] :
                                         RECIP_ODD[HALF_W-1:0];
  assign part = {{HALF_W{1'b0}}, divd_q} * {{DIVD_W{1'b0}}, recip_half};

  always_comb begin
    cst_d = cst_q;
    case (cst_q)
      CV_IDLE: begin
        if (start_i) begin
          cst_d = CV_MUL;
        end
      end
      CV_MUL:  cst_d = CV_LO;
      CV_LO:   cst_d = CV_HI;
      CV_HI:   cst_d = CV_IDLE;
      default: cst_d = CV_IDLE;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (cst_q == CV_LO) begin
      acc_d = {{HALF_W{1'b0}}, part};
    end else if (cst_q == CV_HI) begin
      acc_d = acc_q + {part, {HALF_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= CV_IDLE;
    end else begin
      cst_q <= cst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (cst_q == CV_IDLE)) begin
      a_q <= delay_i;
      b_q <= rate_i;
    end
    if (cst_q == CV_MUL) begin
      divd_q <= prod[PROD_W-1:MS_SHIFT];
    end
    acc_q <= acc_d;
  end

  assign quot = acc_q[ACC_W-1:RECIP_SH];

  // A zero quotient counts as one tick; anything beyond 32 bits saturates.
  always_comb begin
    if (quot == '0) begin
      ticks_o = 32'd1;
    end else if (|quot[QUOT_W-1:WORD_W]) begin
      ticks_o = '1;
    end else begin
      ticks_o = quot[WORD_W-1:0];
    end
  end

  assign done_o = (cst_q == CV_IDLE);

endmodule

`default_nettype wire

### rtl/keyed_one_shot_timer_table.sv
`default_nettype none
// Channel   | Handshake                   | Payload
// s_axis    | s_axis_tvalid_i/_tready_o   | tuser: mode; tdata: key, param, context_req, span_ms
// m_axis    | m_axis_tvalid_o/_tready_i   | tuser: status; tdata: fired_key/param/context; tlast
// cfg       | cfg_we_i (no wait)          | cfg_index_i, cfg_data_i
//
// One item is handled at a time. Every cancel or tick item, and every set with a nonzero key
// and delay, walks the entry memory one entry per cycle unless a tick walk stalls. The next
// item can be taken when the walk ends after a cancel or a tick that fires nothing, when the
// entry is written after a set, and when the result has moved to the output after a refused
// set or a firing tick. The tick conversion of a set runs during the walk. An immediate fire
// waits only for a free output, and a dropped item is discarded while idle. Reset clears the
// live bits and the control state; the memory needs no clearing pass. A tick walk pauses
// while a second firing meets a full output register, so a stalled output slows the walk.

module keyed_one_shot_timer_table #(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input items.
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [127:0] s_axis_tdata_i,  // key, param, context_req, span_ms
  input  wire logic [1:0]   s_axis_tuser_i,  // mode
  // Result items.
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic      [95:0]  m_axis_tdata_o,  // fired_key, fired_param, fired_context
  output logic      [0:0]   m_axis_tuser_o,  // status
  output logic              m_axis_tlast_o,
  // Configuration writes.
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_index_i,
  input  wire logic [9:0]   cfg_data_i
);
  import kott_pkg::*;

  localparam int unsigned IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(NUM_ENTRIES + 1);

  // Control states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SETW  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [CFG_W-1:0] rate_q, min_q;

  logic [1:0]             st_q, st_d;
  logic [1:0]             mode_q;
  logic [WORD_W-1:0]      key_q, param_q, ctx_q;
  logic [CW-1:0]          issue_q, issue_d;
  logic                   dv_q, dv_d;
  logic [IW-1:0]          di_q, di_d;
  logic                   found_q, found_d;
  logic [IW-1:0]          hit_q, hit_d;
  logic [NUM_ENTRIES-1:0] live_q, live_d;
  logic                   pend_v_q, pend_v_d;
  result_t                pend_q, pend_d;
  logic                   out_v_q;
  result_t                out_q;
  logic                   out_last_q;

  logic [1:0]        in_mode;
  logic [WORD_W-1:0] in_key, in_param, in_ctx, in_delay, d_eff;
  logic              accept, out_free, push, push_last;
  logic              conv_start, conv_done;
  logic [WORD_W-1:0] conv_ticks;

  logic              rd_en, wr_en;
  logic [IW-1:0]     rd_addr, wr_addr;
  entry_t            wr_data, rd_entry;

  logic              key_hit, tick_fire, stall, scan_done;
  logic [WORD_W-1:0] t_dec;
  logic              free_ok;
  logic [IW-1:0]     free_idx;

  assign in_mode  = s_axis_tuser_i;
  assign in_key   = s_axis_tdata_i[31:0];
  assign in_param = s_axis_tdata_i[63:32];
  assign in_ctx   = s_axis_tdata_i[95:64];
  assign in_delay = s_axis_tdata_i[127:96];

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_v_q || m_axis_tready_i;

  // Nonzero delays below the floor are raised to it before conversion.
  assign d_eff = (in_delay < {{(WORD_W-CFG_W){1'b0}}, min_q}) ?
                 {{(WORD_W-CFG_W){1'b0}}, min_q} : in_delay;
  assign conv_start = accept && (in_mode == MODE_SET) &&
                      (in_key != '0) && (in_delay != '0);

  kott_tick_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .delay_i (d_eff),
    .rate_i  (rate_q),
    .ticks_o (conv_ticks),
    .done_o  (conv_done)
  );

  kott_entry_ram #(
    .DEPTH (NUM_ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  // Lowest free entry, taken by a set whose key is not in the table.
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Evaluation of the entry whose read data arrived this cycle.
  assign key_hit   = dv_q && live_q[di_q] && (rd_entry.key == key_q);
  assign t_dec     = (rd_entry.ticks != '0) ? (rd_entry.ticks - 32'd1) : '0;
  assign tick_fire = (st_q == ST_SCAN) && dv_q && live_q[di_q] &&
                     (mode_q == MODE_TICK) && (t_dec == '0);
  // A second firing needs the held result moved out first.
  assign stall     = tick_fire && pend_v_q && !out_free;
  assign scan_done = (issue_q == CW'(NUM_ENTRIES)) && !dv_q;

  always_comb begin
    st_d      = st_q;
    issue_d   = issue_q;
    dv_d      = 1'b0;
    di_d      = di_q;
    found_d   = found_q;
    hit_d     = hit_q;
    live_d    = live_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    push      = 1'b0;
    push_last = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = issue_q[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = di_q;
    wr_data   = '{key: rd_entry.key, param: rd_entry.param, ctx: rd_entry.ctx, ticks: t_dec};

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          issue_d = '0;
          found_d = 1'b0;
          case (in_mode)
            MODE_SET: begin
              if (in_key != '0) begin
                if (in_delay == '0) begin
                  // Immediate fire: reported at once, table untouched.
                  pend_v_d = 1'b1;
                  pend_d   = '{status: 1'b0, key: in_key, param: in_param, ctx: in_ctx};
                  st_d     = ST_FLUSH;
                end else begin
                  st_d = ST_SCAN;
                end
              end
            end
            MODE_CANCEL: st_d = ST_SCAN;
            MODE_TICK:   st_d = ST_SCAN;
            default:     st_d = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        dv_d = dv_q;
        if (!stall) begin
          if (issue_q != CW'(NUM_ENTRIES)) begin
            rd_en   = 1'b1;
            issue_d = issue_q + CW'(1);
            dv_d    = 1'b1;
            di_d    = issue_q[IW-1:0];
          end else begin
            dv_d = 1'b0;
          end
        end

        if (dv_q) begin
          case (mode_q)
            MODE_SET: begin
              if (key_hit && !found_q) begin
                found_d = 1'b1;
                hit_d   = di_q;
              end
            end
            MODE_CANCEL: begin
              if (key_hit && !found_q) begin
                found_d      = 1'b1;
                live_d[di_q] = 1'b0;
              end
            end
            MODE_TICK: begin
              if (live_q[di_q]) begin
                if (t_dec == '0) begin
                  if (!stall) begin
                    live_d[di_q] = 1'b0;
                    pend_v_d     = 1'b1;
                    pend_d       = '{status: 1'b0, key: rd_entry.key,
                                     param: rd_entry.param, ctx: rd_entry.ctx};
                    push         = pend_v_q;
                  end
                end else begin
                  wr_en = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end

        if (scan_done) begin
          case (mode_q)
            MODE_SET:  st_d = ST_SETW;
            MODE_TICK: st_d = pend_v_q ? ST_FLUSH : ST_IDLE;
            default:   st_d = ST_IDLE;
          endcase
        end
      end

      ST_SETW: begin
        // Commit once the tick count is ready: rearm, claim, or report full.
        if (conv_done) begin
          wr_data = '{key: key_q, param: param_q, ctx: ctx_q, ticks: conv_ticks};
          if (found_q) begin
            wr_en   = 1'b1;
            wr_addr = hit_q;
            st_d    = ST_IDLE;
          end else if (free_ok) begin
            wr_en            = 1'b1;
            wr_addr          = free_idx;
            live_d[free_idx] = 1'b1;
            st_d             = ST_IDLE;
          end else begin
            pend_v_d = 1'b1;
            pend_d   = '{status: 1'b1, key: key_q, param: param_q, ctx: ctx_q};
            st_d     = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          st_d      = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= TICK_RATE_RST;
      min_q    <= MIN_DELAY_RST;
      st_q     <= ST_IDLE;
      issue_q  <= '0;
      dv_q     <= 1'b0;
      found_q  <= 1'b0;
      live_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TICK_RATE: rate_q <= cfg_data_i;
          CFG_MIN_DELAY: min_q  <= cfg_data_i;
          default: ;
        endcase
      end
      st_q     <= st_d;
      issue_q  <= issue_d;
      dv_q     <= dv_d;
      found_q  <= found_d;
      live_q   <= live_d;
      pend_v_q <= pend_v_d;
      if (push) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_mode;
      key_q   <= in_key;
      param_q <= in_param;
      ctx_q   <= in_ctx;
    end
    di_q   <= di_d;
    hit_q  <= hit_d;
    pend_q <= pend_d;
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.ctx, out_q.param, out_q.key};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire
